// ===== src/wsfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfp_pkg: shared types and constants of the WebSocket frame parser
// Parse phases, frame opcodes and kinds, and the command word that the
// header parser hands to the output stage.
// ----------------------------------------------------------------------------
package wsfp_pkg;

	// parser phases
	typedef enum logic [2:0] {
		PH_HDR0   = 3'd0,
		PH_HDR1   = 3'd1,
		PH_EXTLEN = 3'd2,
		PH_KEY    = 3'd3,
		PH_DATA   = 3'd4
	} phase_t;

	// frame opcodes
	localparam logic [3:0] OP_CONT  = 4'h0;
	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_BIN   = 4'h2;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;
	localparam logic [3:0] OP_PONG  = 4'hA;

	// frame kinds as reported on the output
	typedef enum logic [2:0] {
		KIND_TEXT    = 3'd0,
		KIND_BINARY  = 3'd1,
		KIND_PING    = 3'd2,
		KIND_PONG    = 3'd3,
		KIND_CLOSE   = 3'd4,
		KIND_UNKNOWN = 3'd5
	} kind_t;

	// 7-bit length codes
	localparam logic [6:0] LEN7_SHORT_MAX = 7'd125;
	localparam logic [6:0] LEN7_EXT16    = 7'd126;

	// header field byte counts
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	// queue between parser and output stage
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;

	// command word: one result item before unmasking
	typedef struct packed {
		logic [7:0] data;
		logic [7:0] key;
		logic       byte_valid;
		kind_t      kind;
		logic       last;
	} cmd_t;

	function automatic kind_t kind_of(input logic [3:0] op);
		kind_t k;
		case (op)
			OP_CONT, OP_TEXT: k = KIND_TEXT;
			OP_BIN:           k = KIND_BINARY;
			OP_PING:          k = KIND_PING;
			OP_PONG:          k = KIND_PONG;
			OP_CLOSE:         k = KIND_CLOSE;
			default:          k = KIND_UNKNOWN;
		endcase
		return k;
	endfunction

	function automatic logic is_event(input kind_t k);
		return (k != KIND_TEXT) && (k != KIND_BINARY);
	endfunction

endpackage

// ===== src/websocket_frame_parser_core.sv =====
`timescale 1ns / 1ps
// Path: a result reaches the master side through the command queue entry,
//   written at the edge that accepts the word that causes it, and then the
//   output register, loaded once it is empty or being taken downstream.
// Throughput: one word per cycle, sustained; the parser takes a word in every
//   cycle while the two-entry command queue has room.
// Reset: arst_n clears the parser to wait for a first header byte and empties
//   the queue and output register; no initialization pass is needed.
// ----------------------------------------------------------------------------
// websocket_frame_parser_core: WebSocket frame deframer
// Parses header, extended length and mask key, unmasks data payload words and
// reports control and unknown frames as single events.
// ----------------------------------------------------------------------------
module websocket_frame_parser_core #(
	parameter int LENGTH_BITS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic [3:0] m_axis_tuser,   // [0] byte_valid, [3:1] frame_kind
	output logic       m_axis_tlast    // frame_last
);
	import wsfp_pkg::*;

	logic accept;
	logic push;
	cmd_t push_cmd;
	logic full;
	logic pop;
	logic head_valid;
	cmd_t head_cmd;
	logic byte_valid;
	logic [2:0] frame_kind;

	// accept a word whenever the queue has room
	assign s_axis_tready = !full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	wsfp_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_byte (s_axis_tdata),
		.push    (push),
		.cmd     (push_cmd)
	);

	wsfp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	wsfp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_byte   (m_axis_tdata),
		.byte_valid (byte_valid),
		.frame_kind (frame_kind),
		.frame_last (m_axis_tlast)
	);

	// pack sideband fields
	assign m_axis_tuser = {frame_kind, byte_valid};

endmodule

// ===== src/wsfp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfp_front: header parser
// Walks the frame header, length and mask key one word at a time and issues
// one command per result item: payload words, events and empty frames.
// ----------------------------------------------------------------------------
module wsfp_front #(
	parameter int LENGTH_BITS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        in_byte,
	output logic              push,
	output wsfp_pkg::cmd_t    cmd
);
	import wsfp_pkg::*;

	phase_t                 phase_q, phase_d;
	logic [3:0]             opcode_q, opcode_d;
	logic                   mask_en_q, mask_en_d;
	logic [LENGTH_BITS-1:0] rem_q, rem_d;
	logic [3:0]             fld_q, fld_d;
	logic [31:0]            key_q, key_d;
	logic [1:0]             pos_q, pos_d;
	logic                   len_done;
	logic                   hdr_done;
	logic [6:0]             len7;
	logic [7:0]             key_byte;
	kind_t                  kind;

	assign kind = kind_of(opcode_q);
	assign len7 = in_byte[6:0];

	// pick the key byte for the current payload position
	always_comb begin
		case (pos_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	// next state and command
	always_comb begin
		phase_d   = phase_q;
		opcode_d  = opcode_q;
		mask_en_d = mask_en_q;
		rem_d     = rem_q;
		fld_d     = fld_q;
		key_d     = key_q;
		pos_d     = pos_q;
		len_done  = 1'b0;
		hdr_done  = 1'b0;
		push      = 1'b0;
		cmd       = '0;
		cmd.kind  = kind;

		if (accept) begin
			case (phase_q)
				PH_HDR1: begin
					mask_en_d = in_byte[7];
					if (len7 <= LEN7_SHORT_MAX) begin
						rem_d    = LENGTH_BITS'(len7);
						len_done = 1'b1;
					end else begin
						rem_d   = '0;
						fld_d   = (len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
						phase_d = PH_EXTLEN;
					end
				end
				PH_EXTLEN: begin
					rem_d = {rem_q[LENGTH_BITS-9:0], in_byte};
					fld_d = fld_q - 4'd1;
					if (fld_d == 4'd0) begin
						len_done = 1'b1;
					end
				end
				PH_KEY: begin
					key_d = {key_q[23:0], in_byte};
					fld_d = fld_q - 4'd1;
					if (fld_d == 4'd0) begin
						hdr_done = 1'b1;
					end
				end
				PH_DATA: begin
					pos_d = pos_q + 2'd1;
					rem_d = rem_q - LENGTH_BITS'(1);
					if (rem_d == '0) begin
						phase_d = PH_HDR0;
					end
					if (!is_event(kind)) begin
						push           = 1'b1;
						cmd.data       = in_byte;
						cmd.key        = mask_en_q ? key_byte : 8'd0;
						cmd.byte_valid = 1'b1;
						cmd.last       = (rem_d == '0);
					end
				end
				default: begin
					opcode_d  = in_byte[3:0];
					mask_en_d = 1'b0;
					rem_d     = '0;
					fld_d     = 4'd0;
					pos_d     = 2'd0;
					phase_d   = PH_HDR1;
				end
			endcase

			// length complete: collect the key or finish the header
			if (len_done) begin
				if (mask_en_d) begin
					phase_d = PH_KEY;
					fld_d   = KEY_BYTES;
					key_d   = '0;
				end else begin
					hdr_done = 1'b1;
				end
			end

			// header complete: enter the payload or close the frame
			if (hdr_done) begin
				pos_d   = 2'd0;
				phase_d = (rem_d == '0) ? PH_HDR0 : PH_DATA;
				if (is_event(kind) || rem_d == '0) begin
					push     = 1'b1;
					cmd.last = 1'b1;
				end
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR0;
			opcode_q  <= 4'd0;
			mask_en_q <= 1'b0;
			rem_q     <= '0;
			fld_q     <= 4'd0;
			key_q     <= '0;
			pos_q     <= 2'd0;
		end else begin
			phase_q   <= phase_d;
			opcode_q  <= opcode_d;
			mask_en_q <= mask_en_d;
			rem_q     <= rem_d;
			fld_q     <= fld_d;
			key_q     <= key_d;
			pos_q     <= pos_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_push_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> accept)
		else $error("command issued without an accepted word");
	a_data_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (rem_q != '0))
		else $error("payload phase with no bytes remaining");
	a_key_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_KEY) |-> (fld_q != 4'd0 && fld_q <= KEY_BYTES))
		else $error("key byte count out of range");
`endif

endmodule

// ===== src/wsfp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfp_queue: command queue
// Short register FIFO between the header parser and the output stage.
// ----------------------------------------------------------------------------
module wsfp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  wsfp_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output wsfp_pkg::cmd_t head_cmd
);
	import wsfp_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign full       = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];

	// store pushed words
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (QPTR_W+1)'(1);
				2'b01:   cnt_q <= cnt_q - (QPTR_W+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== src/wsfp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfp_back: output stage
// Takes commands from the queue, unmasks payload words and holds each
// result in an output register until the downstream side takes it.
// ----------------------------------------------------------------------------
module wsfp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  wsfp_pkg::cmd_t head_cmd,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic           byte_valid,
	output logic [2:0]     frame_kind,
	output logic           frame_last
);
	import wsfp_pkg::*;

	logic       valid_q;
	logic [7:0] byte_q;
	logic       bvalid_q;
	kind_t      kind_q;
	logic       last_q;

	assign pop        = head_valid && (!valid_q || out_ready);
	assign out_valid  = valid_q;
	assign out_byte   = byte_q;
	assign byte_valid = bvalid_q;
	assign frame_kind = kind_q;
	assign frame_last = last_q;

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// load and unmask the next result
	always_ff @(posedge clk) begin
		if (pop) begin
			byte_q   <= head_cmd.data ^ head_cmd.key;
			bvalid_q <= head_cmd.byte_valid;
			kind_q   <= head_cmd.kind;
			last_q   <= head_cmd.last;
		end
	end

`ifndef NO_ASSERTIONS
	a_empty_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !bvalid_q) |-> (byte_q == 8'd0))
		else $error("result without payload carries a nonzero byte");
	a_event_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && is_event(kind_q)) |-> (last_q && !bvalid_q))
		else $error("event result not a single final word");
	a_no_pop_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !out_ready) |-> !pop)
		else $error("queue popped while output register is held");
`endif

endmodule
